/* design/trial_division_prime_test_macros.svh */
// Assertion macros shared by the checker of the trial division prime test.
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// antecedent true at one edge implies consequent at the next edge
`define TDPT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tdpt: next-cycle check failed");

// antecedent implies consequent at the same edge
`define TDPT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tdpt: same-cycle check failed");

`endif

/* design/tdpt_pkg.sv */
// Shared constant for the trial division prime test.
package tdpt_pkg;
	localparam int NUM_WIDTH_DEF = 32;
endpackage

/* design/tdpt_div.sv */
// Radix-2 restoring divider: one quotient bit per cycle, gives quotient and remainder.
module tdpt_div import tdpt_pkg::*; #(
	parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NUM_WIDTH-1:0] dividend,
	input  logic [NUM_WIDTH-1:0] divisor,
	output logic                 done,
	output logic [NUM_WIDTH-1:0] quot,
	output logic [NUM_WIDTH:0]   rem
);
	localparam int CW = $clog2(NUM_WIDTH + 1);

	logic [NUM_WIDTH:0]   rem_q;
	logic [NUM_WIDTH-1:0] dvd_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [NUM_WIDTH:0]   shifted;
	logic [NUM_WIDTH+1:0] diff;
	logic                 qbit;

	assign shifted = {rem_q[NUM_WIDTH-1:0], dvd_q[NUM_WIDTH-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divisor};
	assign qbit    = ~diff[NUM_WIDTH+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[NUM_WIDTH:0] : shifted;
			dvd_q <= {dvd_q[NUM_WIDTH-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q;
endmodule

/* design/trial_division_prime_test.sv */
// Top level of the trial division prime test: sequencer around a bit-serial divider.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------
//  candidate | cand_valid / cand_stall    | candidate [NUM_WIDTH-1:0] signed
//  result    | result_valid / result_stall| is_prime
//
// Each divisor tried loads the divider, takes NUM_WIDTH quotient bits from it and is
// then evaluated. An item tries divisors from 2 up to about sqrt(n), or until an
// exact divisor is found; negatives, 0 and 1 skip the divider.
// Reset clears the sequencer and the result valid flag.
// A stalled result holds the finished answer; the next item is taken meanwhile
// and waits for that slot only when its own answer is ready.
module trial_division_prime_test import tdpt_pkg::*; #(
	parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cand_valid,
	output logic                        cand_stall,
	input  logic signed [NUM_WIDTH-1:0] candidate,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic                        is_prime
);
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_START = 2'd1;
	localparam logic [1:0] S_WAIT  = 2'd2;
	localparam logic [1:0] S_HOLD  = 2'd3;

	logic [1:0]           state_q;
	logic [NUM_WIDTH-1:0] n_q;
	logic [NUM_WIDTH-1:0] d_q;
	logic                 prime_q;
	logic                 out_valid_q;
	logic                 out_prime_q;
	logic                 div_done;
	logic [NUM_WIDTH-1:0] div_quot;
	logic [NUM_WIDTH:0]   div_rem;
	logic                 accept;
	logic                 out_free;

	assign accept   = cand_valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || !result_stall;

	tdpt_div #(.NUM_WIDTH(NUM_WIDTH)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_START),
		.dividend (n_q),
		.divisor  (d_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_HOLD) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						// negatives, zero and one answer at once
						if (candidate[NUM_WIDTH-1] || (candidate[NUM_WIDTH-1:1] == '0)) begin
							state_q <= S_HOLD;
						end else begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_done) begin
						// stop once d exceeds n / d, or on an exact divisor
						if ((d_q > div_quot) || (div_rem == '0)) begin
							state_q <= S_HOLD;
						end else begin
							state_q <= S_START;
						end
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q     <= candidate;
			d_q     <= NUM_WIDTH'(2);
			prime_q <= 1'b0;
		end else if ((state_q == S_WAIT) && div_done) begin
			if (d_q > div_quot) begin
				prime_q <= 1'b1;
			end else if (div_rem != '0) begin
				d_q <= d_q + NUM_WIDTH'(1);
			end
		end
		if ((state_q == S_HOLD) && out_free) begin
			out_prime_q <= prime_q;
		end
	end

	assign cand_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;
	assign is_prime     = out_prime_q;
endmodule

/* design/tdpt_chk.sv */
// Port-level checker for the trial division prime test, bound to the top level.
`include "trial_division_prime_test_macros.svh"

module tdpt_chk import tdpt_pkg::*; #(
	parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cand_valid,
	input logic                        cand_stall,
	input logic signed [NUM_WIDTH-1:0] candidate,
	input logic                        result_valid,
	input logic                        result_stall,
	input logic                        is_prime
);
	logic cand_take;

	assign cand_take = cand_valid && !cand_stall;

	`TDPT_ASSERT_NEXT(a_cand_holds, cand_valid && cand_stall, $stable(candidate))
	`TDPT_ASSERT_NEXT(a_result_holds, result_valid && result_stall, result_valid)
	`TDPT_ASSERT_NEXT(a_payload_holds, result_valid && result_stall, $stable(is_prime))
	`TDPT_ASSERT_NEXT(a_busy_after_take, cand_take, cand_stall)
	`TDPT_ASSERT_SAME(a_result_after_busy, $rose(result_valid), $past(cand_stall))
endmodule

bind trial_division_prime_test tdpt_chk #(.NUM_WIDTH(NUM_WIDTH)) u_tdpt_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.cand_valid   (cand_valid),
	.cand_stall   (cand_stall),
	.candidate    (candidate),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.is_prime     (is_prime)
);

/* verif/prime_checker.sv */
`timescale 1ns / 1ps
// Checker for the trial division prime test: predicts every answer and compares results in order.
module prime_checker #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cand_valid,
	input  logic                cand_stall,
	input  logic signed [W-1:0] candidate,
	input  logic                result_valid,
	input  logic                result_stall,
	input  logic                is_prime,
	output int                  mismatches,
	output int                  pending
);

	typedef struct {
		logic signed [W-1:0] value;
		bit                  prime;
	} verdict_t;

	verdict_t verdicts_q[$];
	int       errors = 0;

	assign mismatches = errors;

	function automatic bit predict_prime(logic signed [W-1:0] value);
		longint unsigned n;
		longint unsigned d;
		if (value < 0)
			return 1'b0;
		n = longint'(value);
		if (n <= 1)
			return 1'b0;
		// bound as d <= n / d so the square never wraps
		for (d = 2; d <= n / d; d++) begin
			if (n % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		verdict_t got;
		if (!arst_n) begin
			verdicts_q.delete();
			pending <= 0;
		end else begin
			// retire first: a result never belongs to the item taken at the same edge
			if (result_valid && !result_stall) begin
				if (verdicts_q.size() == 0) begin
					report_mismatch($sformatf("is_prime %0b with no item pending", is_prime));
				end else begin
					want = verdicts_q.pop_front();
					if (is_prime !== want.prime)
						report_mismatch($sformatf("candidate %0d: is_prime %0b, predicted %0b",
							want.value, is_prime, want.prime));
				end
			end
			if (cand_valid && !cand_stall) begin
				got.value = candidate;
				got.prime = predict_prime(candidate);
				verdicts_q.insert(verdicts_q.size(), got);
			end
			pending <= verdicts_q.size();
		end
	end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the trial division prime test: candidate stimulus, result stall and verdict.
module tb;
	import tdpt_pkg::*;

	localparam int W           = NUM_WIDTH_DEF;
	localparam int NUM_RANDOM  = 80;
	localparam int TAIL_CYCLES = 200;
	// the limit allows for the largest 32-bit prime, which tries every divisor up to its root
	localparam int IDLE_LIMIT  = 8_000_000;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                cand_valid   = 1'b0;
	logic signed [W-1:0] candidate    = '0;
	logic                result_stall = 1'b0;
	logic                cand_stall;
	logic                result_valid;
	logic                is_prime;
	int                  mismatches;
	int                  pending;
	bit                  calm         = 1'b1;
	int                  idle_cycles;

	// negatives, zero, one, the first primes, prime squares, and the top of the range
	logic signed [W-1:0] corner_cases [20] = '{
		32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, -32'sd7,
		32'sd0, 32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd9, 32'sd25, 32'sd49, 32'sd97,
		32'sd65521, 32'sd999983, 32'sd1018081,
		32'sd2147483646, 32'sd2147483645, 32'sd2147483647
	};

	trial_division_prime_test #(
		.NUM_WIDTH(W)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cand_valid  (cand_valid),
		.cand_stall  (cand_stall),
		.candidate   (candidate),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.is_prime    (is_prime)
	);

	prime_checker #(
		.W(W)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cand_valid  (cand_valid),
		.cand_stall  (cand_stall),
		.candidate   (candidate),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.is_prime    (is_prime),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// mostly small numbers; large ones carry a small factor so they finish fast
	function automatic logic signed [W-1:0] random_candidate();
		int unsigned factors [6] = '{2, 3, 5, 7, 11, 13};
		int unsigned kind;
		int unsigned p;
		int unsigned k;
		kind = $urandom_range(0, 99);
		if (kind < 50)
			return $urandom_range(0, 4095);
		if (kind < 60)
			return $urandom_range(4096, 1 << 18);
		if (kind < 78)
			return $urandom | 32'h8000_0000;
		p = factors[$urandom_range(0, 5)];
		k = $urandom_range(1, 32'h7FFF_FFFF / p);
		return p * k;
	endfunction

	task automatic send_item(input logic signed [W-1:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cand_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cand_valid <= 1'b1;
		candidate  <= value;
		do @(posedge clk); while (cand_stall);
	endtask

	// hold the sender until every answer is back
	task automatic drain();
		cand_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = pick_gap();
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cand_valid && !cand_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb failed");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		calm = 1'b1;
		foreach (corner_cases[i])
			send_item(corner_cases[i]);
		drain();

		for (int i = 0; i < NUM_RANDOM; i++) begin
			calm = (i >= 40 && i < 55);
			if ($urandom_range(0, 29) == 0)
				drain();
			send_item(random_candidate());
		end
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
